FILE: hw/rtl/psa_pkg.sv
// Package with shared types and constants of the paged slot allocator.
package psa_pkg;

    localparam int MaxResults = 32;
    localparam int PageLenMax = 1024;

    localparam logic ActLoad  = 1'b0;
    localparam logic ActAlloc = 1'b1;

    // Classified request passed from the front part to the back part.
    typedef struct packed {
        logic        err;
        logic [23:0] pos0;
        logic [30:0] head_slot;
        logic [10:0] head;
        logic [10:0] full;
        logic [10:0] tail;
        logic [10:0] page0;
        logic [10:0] need;
        logic [10:0] plen;
        logic [23:0] tok_tot;
        logic [10:0] pag_tot;
    } t_job;

    // One result item.
    typedef struct packed {
        logic [23:0] out_position;
        logic [30:0] slot_base;
        logic [10:0] run_count;
        logic        error_flag;
        logic [23:0] tokens_total;
        logic [10:0] pages_total;
        logic        last_of_request;
    } t_res;

endpackage

FILE: hw/rtl/psa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module psa_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/psa_divider.sv
// Iterative unsigned divider: 24-bit dividend by 11-bit divisor, one bit a cycle.
module psa_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [10:0] i_divisor,
    output logic        o_done,
    output logic [23:0] o_quotient,
    output logic [10:0] o_remainder
);
    logic [23:0] r_quo, n_quo;
    logic [11:0] r_rem, n_rem;
    logic [10:0] r_div;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [11:0] shifted;

    // Restoring division step.
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        shifted = {r_rem[10:0], r_quo[23]};
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_div}) begin
                n_rem = shifted - {1'b0, r_div};
                n_quo = {r_quo[22:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[22:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[10:0];
endmodule

FILE: hw/rtl/psa_front.sv
// Front part: accepts items, writes the free table and classifies requests.
module psa_front #(
    parameter int FreeTableDepth     = 1024,
    parameter int MaxPagesPerRequest = 30
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_action,
    input  logic [9:0]                        i_table_index,
    input  logic [23:0]                       i_page_number,
    input  logic [23:0]                       i_prior_length,
    input  logic [23:0]                       i_new_length,
    input  logic [31:0]                       i_last_slot,
    input  logic                              i_end_of_batch,
    input  logic [10:0]                       i_page_length,
    input  logic                              i_back_busy,
    output logic                              o_tbl_we,
    output logic [$clog2(FreeTableDepth)-1:0] o_tbl_waddr,
    output logic [23:0]                       o_tbl_wdata,
    output logic                              o_job_valid,
    output psa_pkg::t_job                     o_job,
    input  logic                              i_job_ready
);
    import psa_pkg::*;

    localparam int AW = $clog2(FreeTableDepth);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StDivA  = 3'd1;
    localparam logic [2:0] StDivB  = 3'd2;
    localparam logic [2:0] StMul   = 3'd3;
    localparam logic [2:0] StClass = 3'd4;
    localparam logic [2:0] StOut   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [23:0] r_prior, r_newl;
    logic [31:0] r_last;
    logic        r_eob;
    logic [10:0] r_p;
    logic [23:0] r_pp, r_pn, r_qn;
    logic [10:0] r_rn;
    logic [34:0] r_up;
    logic [23:0] r_tok_sum, n_tok_sum;
    logic [10:0] r_pag_sum, n_pag_sum;
    t_job        r_job, n_job;
    logic        r_job_valid, n_job_valid;

    logic        accept;
    logic        div_start, div_done;
    logic [23:0] div_dividend, div_quo;
    logic [10:0] div_rem;
    logic [10:0] p_clamped;

    // Page length clamp.
    always_comb begin
        if (i_page_length == 11'd0) begin
            p_clamped = 11'd1;
        end else if (i_page_length > 11'(PageLenMax)) begin
            p_clamped = 11'(PageLenMax);
        end else begin
            p_clamped = i_page_length;
        end
    end

    // A load waits until the back part has read every entry of the request before it.
    assign accept = i_push && !o_full;
    assign o_full = (r_state != StIdle) || r_job_valid ||
                    ((i_action == ActLoad) && i_back_busy);

    // Table writes straight from loads.
    assign o_tbl_we    = accept && (i_action == ActLoad) &&
                         ({7'd0, i_table_index} < 17'(FreeTableDepth));
    assign o_tbl_waddr = AW'(i_table_index);
    assign o_tbl_wdata = i_page_number;

    assign div_start    = (accept && i_action == ActAlloc) ||
                          (r_state == StDivA && div_done);
    assign div_dividend = (r_state == StDivA) ? r_newl : i_prior_length;

    psa_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   ((r_state == StDivA) ? r_p : p_clamped),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Classification sequencer.
    always_comb begin
        logic [10:0] need11;
        logic [23:0] need;
        logic [34:0] down;
        logic [34:0] newl35;
        logic [34:0] head_end;
        logic [23:0] full;
        logic        err;
        logic [11:0] pg_end;
        n_state     = r_state;
        n_tok_sum   = r_tok_sum;
        n_pag_sum   = r_pag_sum;
        n_job       = r_job;
        n_job_valid = r_job_valid;
        need        = r_pn - r_pp;
        need11      = need[10:0];
        newl35      = {11'd0, r_newl};
        down        = 35'(r_qn) * 35'(r_p);
        head_end    = (newl35 < r_up) ? newl35 : r_up;
        full        = r_qn - r_pp;
        pg_end      = {1'b0, r_pag_sum} + 12'(need11);
        err         = (r_newl < r_prior) ||
                      (need > 24'(MaxPagesPerRequest)) ||
                      (need > 24'(MaxResults - 1)) ||
                      ({5'd0, pg_end} > 17'(FreeTableDepth)) ||
                      (need[23:11] != '0 && pg_end[11]);
        if (need[23:11] != '0) begin
            err = 1'b1;
        end
        if (i_job_ready && r_job_valid) begin
            n_job_valid = 1'b0;
        end
        unique case (r_state)
            StIdle: begin
                if (div_start) begin
                    n_state = StDivA;
                end
            end
            StDivA: begin
                if (div_done) begin
                    n_state = StDivB;
                end
            end
            StDivB: begin
                if (div_done) begin
                    n_state = StMul;
                end
            end
            StMul: begin
                n_state = StClass;
            end
            StClass: begin
                n_state = StOut;
            end
            StOut: begin
                n_job.err       = err;
                n_job.pos0      = r_tok_sum;
                n_job.head_slot = 31'(r_last + 32'd1);
                n_job.head      = 11'(head_end - {11'd0, r_prior});
                n_job.full      = (r_newl > r_up[23:0] && down[23:0] > r_up[23:0] &&
                                   r_up[34:24] == '0) ? full[10:0] : 11'd0;
                n_job.tail      = (r_newl > r_up[23:0] && r_up[34:24] == '0 &&
                                   need11 != '0) ? r_rn : 11'd0;
                n_job.page0     = r_pag_sum;
                n_job.need      = need11;
                n_job.plen      = r_p;
                n_job.tok_tot   = r_tok_sum + r_newl - r_prior;
                n_job.pag_tot   = r_pag_sum + need11;
                n_job_valid     = 1'b1;
                n_tok_sum       = r_eob ? 24'd0 : n_job.tok_tot;
                n_pag_sum       = r_eob ? 11'd0 : n_job.pag_tot;
                n_state         = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_job_valid <= 1'b0;
            r_tok_sum   <= '0;
            r_pag_sum   <= '0;
        end else begin
            r_state     <= n_state;
            r_job_valid <= n_job_valid;
            r_tok_sum   <= n_tok_sum;
            r_pag_sum   <= n_pag_sum;
        end
        r_job <= n_job;
        if (accept) begin
            r_prior <= i_prior_length;
            r_newl  <= i_new_length;
            r_last  <= i_last_slot;
            r_eob   <= i_end_of_batch;
            r_p     <= p_clamped;
        end
        // Quotient of the ceiling is taken from the floor and remainder.
        if (r_state == StDivA && div_done) begin
            r_pp <= div_quo + 24'(div_rem != '0);
        end
        if (r_state == StDivB && div_done) begin
            r_qn <= div_quo;
            r_rn <= div_rem;
            r_pn <= div_quo + 24'(div_rem != '0);
        end
        if (r_state == StMul) begin
            r_up <= 35'(r_pp) * 35'(r_p);
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
endmodule

FILE: hw/rtl/psa_back.sv
// Back part: walks a classified request and emits its slot runs.
module psa_back #(
    parameter int FreeTableDepth = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    input  psa_pkg::t_job                     i_job,
    output logic                              o_job_ready,
    output logic                              o_busy,
    output logic [$clog2(FreeTableDepth)-1:0] o_tbl_raddr,
    input  logic [23:0]                       i_tbl_rdata,
    output logic                              o_empty,
    input  logic                              i_pop,
    output psa_pkg::t_res                     o_res
);
    import psa_pkg::*;

    localparam int AW = $clog2(FreeTableDepth);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StHead = 3'd1;
    localparam logic [2:0] StRead = 3'd2;
    localparam logic [2:0] StMul  = 3'd3;
    localparam logic [2:0] StEmit = 3'd4;

    logic [2:0]  r_state, n_state;
    t_job        r_job, n_job;
    logic [10:0] r_k, n_k;
    logic [23:0] r_off, n_off;
    logic [30:0] r_slot, n_slot;
    logic        r_full_v, n_full_v;
    t_res        r_res, n_res;
    logic        r_tail_phase, n_tail_phase;
    logic [10:0] page_idx;
    logic        more;

    assign o_job_ready = (r_state == StIdle);
    assign o_busy      = (r_state != StIdle);
    assign page_idx    = r_tail_phase ? (r_job.page0 + r_job.need - 11'd1)
                                      : (r_job.page0 + r_k);
    assign o_tbl_raddr = AW'(page_idx);

    // Run sequencer: an error or empty result, or head, full pages, then the tail page.
    always_comb begin
        t_res rr;
        n_state      = r_state;
        n_job        = r_job;
        n_k          = r_k;
        n_off        = r_off;
        n_slot       = r_slot;
        n_full_v     = r_full_v;
        n_res        = r_res;
        n_tail_phase = r_tail_phase;
        more         = 1'b0;
        rr.out_position    = r_job.pos0 + r_off;
        rr.slot_base       = 31'd0;
        rr.run_count       = 11'd0;
        rr.error_flag      = 1'b0;
        rr.tokens_total    = r_job.tok_tot;
        rr.pages_total     = r_job.pag_tot;
        rr.last_of_request = 1'b0;
        if (r_full_v && i_pop) begin
            n_full_v = 1'b0;
        end
        unique case (r_state)
            StIdle: begin
                if (i_job_valid) begin
                    n_job        = i_job;
                    n_k          = 11'd0;
                    n_off        = 24'd0;
                    n_tail_phase = 1'b0;
                    n_state      = StHead;
                end
            end
            StHead: begin
                if (!n_full_v) begin
                    more = (r_job.full != 0) || (r_job.tail != 0);
                    if (r_job.err) begin
                        rr.error_flag      = 1'b1;
                        rr.last_of_request = 1'b1;
                        n_res = rr; n_full_v = 1'b1; n_state = StIdle;
                    end else if (r_job.head != 0) begin
                        rr.slot_base       = r_job.head_slot;
                        rr.run_count       = r_job.head;
                        rr.last_of_request = !more;
                        n_res = rr; n_full_v = 1'b1;
                        n_off   = 24'(r_job.head);
                        n_state = more ? StRead : StIdle;
                        n_tail_phase = (r_job.full == 0);
                    end else if (more) begin
                        n_tail_phase = (r_job.full == 0);
                        n_state      = StRead;
                    end else begin
                        rr.last_of_request = 1'b1;
                        n_res = rr; n_full_v = 1'b1; n_state = StIdle;
                    end
                end
            end
            StRead: begin
                n_state = StMul;
            end
            StMul: begin
                n_slot  = 31'(35'(i_tbl_rdata) * 35'(r_job.plen));
                n_state = StEmit;
            end
            StEmit: begin
                if (!n_full_v) begin
                    rr.slot_base = r_slot;
                    if (!r_tail_phase) begin
                        rr.run_count = r_job.plen;
                        more = (r_k + 11'd1 < r_job.full) || (r_job.tail != 0);
                        n_off = r_off + 24'(r_job.plen);
                        n_k   = r_k + 11'd1;
                        n_tail_phase = !(r_k + 11'd1 < r_job.full);
                    end else begin
                        rr.run_count = r_job.tail;
                        more = 1'b0;
                    end
                    rr.last_of_request = !more;
                    n_res = rr; n_full_v = 1'b1;
                    n_state = more ? StRead : StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_full_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_full_v <= n_full_v;
        end
        r_job        <= n_job;
        r_k          <= n_k;
        r_off        <= n_off;
        r_slot       <= n_slot;
        r_res        <= n_res;
        r_tail_phase <= n_tail_phase;
    end

    assign o_empty = !r_full_v;
    assign o_res   = r_res;
endmodule

FILE: hw/rtl/paged_slot_allocator.sv
// Top level of the paged slot allocator.
// A load item writes one free-table entry once the back part has
// finished reading the table for the request before it. A request item is
// classified by the front part through two serial 24-bit divisions by
// the page length at one bit a cycle, and then emits one result per run:
// the head run first, then each further page after the free-table read
// and the page multiply. A one-entry queue between the parts lets the
// front classify the next request while the back emits.
module paged_slot_allocator #(
    parameter int FREE_TABLE_DEPTH      = 1024,
    parameter int MAX_PAGES_PER_REQUEST = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [9:0]  i_table_index,
    input  logic [23:0] i_page_number,
    input  logic [23:0] i_prior_length,
    input  logic [23:0] i_new_length,
    input  logic [31:0] i_last_slot,
    input  logic        i_end_of_batch,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] o_out_position,
    output logic [30:0] o_slot_base,
    output logic [10:0] o_run_count,
    output logic        o_error_flag,
    output logic [23:0] o_tokens_total,
    output logic [10:0] o_pages_total,
    output logic        o_last_of_request
);
    import psa_pkg::*;

    localparam int AW = $clog2(FREE_TABLE_DEPTH);

    logic [10:0]   r_page_length;
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    logic [23:0]   tbl_wdata, tbl_rdata;
    logic          job_valid, job_ready;
    logic          back_busy;
    t_job          job;
    t_res          res;

    // Page length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_length <= 11'd16;
        end else if (i_cfg_we) begin
            r_page_length <= i_cfg_wdata;
        end
    end

    psa_front #(
        .FreeTableDepth     (FREE_TABLE_DEPTH),
        .MaxPagesPerRequest (MAX_PAGES_PER_REQUEST)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_action       (i_action),
        .i_table_index  (i_table_index),
        .i_page_number  (i_page_number),
        .i_prior_length (i_prior_length),
        .i_new_length   (i_new_length),
        .i_last_slot    (i_last_slot),
        .i_end_of_batch (i_end_of_batch),
        .i_page_length  (r_page_length),
        .i_back_busy    (back_busy),
        .o_tbl_we       (tbl_we),
        .o_tbl_waddr    (tbl_waddr),
        .o_tbl_wdata    (tbl_wdata),
        .o_job_valid    (job_valid),
        .o_job          (job),
        .i_job_ready    (job_ready)
    );

    psa_ram #(
        .Width (24),
        .Depth (FREE_TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    psa_back #(
        .FreeTableDepth (FREE_TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_busy      (back_busy),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_out_position    = res.out_position;
    assign o_slot_base       = res.slot_base;
    assign o_run_count       = res.run_count;
    assign o_error_flag      = res.error_flag;
    assign o_tokens_total    = res.tokens_total;
    assign o_pages_total     = res.pages_total;
    assign o_last_of_request = res.last_of_request;

    // An error result is always the last one of its request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_flag) |-> o_last_of_request)
        else $error("error result not marked last");

    // An error result carries no slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_flag) |-> (o_run_count == 11'd0))
        else $error("error result with slots");

    // A waiting result holds until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_slot_base)))
        else $error("waiting result changed");
endmodule

FILE: verif/paged_slot_allocator_tb.sv
// Self-checking testbench for the paged slot allocator with a run predictor.
`timescale 1ns / 1ps

module paged_slot_allocator_tb;
    import psa_pkg::*;

    localparam int TableDepth = 1024;
    localparam int MaxPages   = 30;
    localparam int Mask24     = 24'hFFFFFF;
    localparam int Mask11     = 11'h7FF;
    localparam int DrainCycles = 250;

    // One input item as the sender sees it.
    typedef struct {
        logic        action;
        logic [9:0]  table_index;
        logic [23:0] page_number;
        logic [23:0] prior_length;
        logic [23:0] new_length;
        logic [31:0] last_slot;
        logic        end_of_batch;
    } t_alloc_item;

    // Tracks the free table, the batch sums and the runs still to come.
    class t_run_tracker;
        logic [23:0]  free_pages [TableDepth];
        bit           entry_loaded [TableDepth];
        int unsigned  page_len = 16;
        int unsigned  token_sum = 0;
        int unsigned  page_sum = 0;
        t_res         pending_runs [$];
        int unsigned  mismatches = 0;
        int unsigned  runs_seen = 0;
        int unsigned  requests = 0;
        int unsigned  loads = 0;
        int unsigned  error_runs = 0;

        function int unsigned clamped_len();
            if (page_len == 0) return 1;
            if (page_len > PageLenMax) return PageLenMax;
            return page_len;
        endfunction

        function int unsigned pages_needed(int unsigned prior, int unsigned newl);
            int unsigned p;
            p = clamped_len();
            return (newl + p - 1) / p - (prior + p - 1) / p;
        endfunction

        function t_res make_run(int unsigned pos, logic [63:0] slot, int unsigned count,
                                bit err, int unsigned tok, int unsigned pag);
            t_res r;
            r.out_position    = pos[23:0];
            r.slot_base       = slot[30:0];
            r.run_count       = count[10:0];
            r.error_flag      = err;
            r.tokens_total    = tok[23:0];
            r.pages_total     = pag[10:0];
            r.last_of_request = 1'b0;
            return r;
        endfunction

        // Works out the runs that an accepted item causes.
        function void note_item(t_alloc_item it);
            int unsigned p, prior, newl, pages_prior, need, pos0, page0, tok, pag;
            int unsigned up, head_end, head, offset, down, nfull, tail;
            bit err;
            t_res runs [$];
            if (it.action == ActLoad) begin
                free_pages[it.table_index] = it.page_number;
                entry_loaded[it.table_index] = 1'b1;
                loads++;
                return;
            end
            requests++;
            p = clamped_len();
            prior = it.prior_length;
            newl = it.new_length;
            pages_prior = (prior + p - 1) / p;
            need = pages_needed(prior, newl);
            pos0 = token_sum;
            page0 = page_sum;
            tok = (token_sum + newl - prior) & Mask24;
            pag = (page_sum + need) & Mask11;
            err = newl < prior;
            if (!err && (need > MaxPages || need + 1 > MaxResults || page0 + need > TableDepth))
                err = 1'b1;
            if (err) begin
                runs.push_back(make_run(pos0, 0, 0, 1'b1, tok, pag));
            end else begin
                up = pages_prior * p;
                head_end = newl < up ? newl : up;
                head = head_end - prior;
                offset = 0;
                if (head > 0) begin
                    runs.push_back(make_run(pos0, 64'(it.last_slot + 32'd1), head, 1'b0,
                                            tok, pag));
                    offset = head;
                end
                if (newl > up) begin
                    down = (newl / p) * p;
                    nfull = down > up ? (down - up) / p : 0;
                    for (int k = 0; k < nfull; k++) begin
                        runs.push_back(make_run(pos0 + offset,
                                                64'(free_pages[page0 + k]) * p, p, 1'b0,
                                                tok, pag));
                        offset += p;
                    end
                    tail = newl - down;
                    if (tail > 0 && need > 0)
                        runs.push_back(make_run(pos0 + offset,
                                                64'(free_pages[page0 + need - 1]) * p, tail,
                                                1'b0, tok, pag));
                end
                if (runs.size() == 0)
                    runs.push_back(make_run(pos0, 0, 0, 1'b0, tok, pag));
            end
            runs[runs.size() - 1].last_of_request = 1'b1;
            foreach (runs[i]) pending_runs.push_back(runs[i]);
            if (it.end_of_batch) begin
                token_sum = 0;
                page_sum = 0;
            end else begin
                token_sum = tok;
                page_sum = pag;
            end
        endfunction

        // Compares one accepted run with the oldest one waiting.
        function void check_run(t_res got);
            t_res want;
            runs_seen++;
            if (got.error_flag) error_runs++;
            if (pending_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected run at %0t: %p", $realtime, got);
                return;
            end
            want = pending_runs.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("run mismatch at %0t", $realtime);
                    $display("  expected %p", want);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_action;
    logic [9:0]  i_table_index;
    logic [23:0] i_page_number;
    logic [23:0] i_prior_length;
    logic [23:0] i_new_length;
    logic [31:0] i_last_slot;
    logic        i_end_of_batch;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        empty;
    logic        pop;
    logic [23:0] o_out_position;
    logic [30:0] o_slot_base;
    logic [10:0] o_run_count;
    logic        o_error_flag;
    logic [23:0] o_tokens_total;
    logic [10:0] o_pages_total;
    logic        o_last_of_request;

    t_run_tracker tracker = new();
    bit hold_request = 1'b0;

    paged_slot_allocator #(
        .FREE_TABLE_DEPTH      (TableDepth),
        .MAX_PAGES_PER_REQUEST (MaxPages)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_action          (i_action),
        .i_table_index     (i_table_index),
        .i_page_number     (i_page_number),
        .i_prior_length    (i_prior_length),
        .i_new_length      (i_new_length),
        .i_last_slot       (i_last_slot),
        .i_end_of_batch    (i_end_of_batch),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .empty             (empty),
        .pop               (pop),
        .o_out_position    (o_out_position),
        .o_slot_base       (o_slot_base),
        .o_run_count       (o_run_count),
        .o_error_flag      (o_error_flag),
        .o_tokens_total    (o_tokens_total),
        .o_pages_total     (o_pages_total),
        .o_last_of_request (o_last_of_request)
    );

    // Clock and reset.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard limit on the run.
    initial begin
        #8_000_000;
        $display("timeout with %0d runs outstanding", tracker.pending_runs.size());
        $display("paged_slot_allocator_tb: errors");
        $finish;
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && pop && !empty) begin
            got.out_position    = o_out_position;
            got.slot_base       = o_slot_base;
            got.run_count       = o_run_count;
            got.error_flag      = o_error_flag;
            got.tokens_total    = o_tokens_total;
            got.pages_total     = o_pages_total;
            got.last_of_request = o_last_of_request;
            tracker.check_run(got);
        end
    end

    // Receiver: a stall pattern that changes every so often, plus long hold-offs on request.
    initial begin
        int unsigned cyc;
        int unsigned held;
        cyc = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_request) begin
                pop <= 1'b0;
                held = 0;
                while (held < 500) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_request = 1'b0;
            end else begin
                case ((cyc / 60) % 3)
                    0: pop <= 1'b1;
                    1: pop <= $urandom_range(0, 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one item and waits until it is taken.
    task automatic send_item(t_alloc_item it);
        @(negedge i_clk);
        push           <= 1'b1;
        i_action       <= it.action;
        i_table_index  <= it.table_index;
        i_page_number  <= it.page_number;
        i_prior_length <= it.prior_length;
        i_new_length   <= it.new_length;
        i_last_slot    <= it.last_slot;
        i_end_of_batch <= it.end_of_batch;
        do @(posedge i_clk); while (full);
        tracker.note_item(it);
    endtask

    task automatic send_load(int unsigned idx, logic [23:0] page);
        t_alloc_item it;
        it.action       = ActLoad;
        it.table_index  = idx[9:0];
        it.page_number  = page;
        it.prior_length = 24'($urandom);
        it.new_length   = 24'($urandom);
        it.last_slot    = $urandom;
        it.end_of_batch = $urandom_range(0, 1);
        send_item(it);
    endtask

    // Loads any table entry that the request is about to read, then sends the request.
    task automatic send_request(int unsigned prior, int unsigned newl, logic [31:0] last,
                                bit eob);
        t_alloc_item it;
        int unsigned need;
        int unsigned base;
        need = tracker.pages_needed(prior, newl);
        base = tracker.page_sum;
        if (newl >= prior && need <= MaxPages && base + need <= TableDepth)
            for (int k = 0; k < need; k++)
                if (!tracker.entry_loaded[base + k])
                    send_load(base + k, 24'($urandom));
        it.action       = ActAlloc;
        it.table_index  = 10'($urandom);
        it.page_number  = 24'($urandom);
        it.prior_length = prior[23:0];
        it.new_length   = newl[23:0];
        it.last_slot    = last;
        it.end_of_batch = eob;
        send_item(it);
    endtask

    task automatic idle_sender(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    // Waits for the block to go quiet, then writes the page length.
    task automatic write_page_length(int unsigned len);
        idle_sender(1);
        while (tracker.pending_runs.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len[10:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.page_len = len;
    endtask

    // Random items: mostly well-formed growth, some shrinking, wild lengths and table loads.
    task automatic random_requests(int unsigned count);
        int unsigned p, prior, newl, burst, kind;
        burst = $urandom_range(1, 8);
        for (int n = 0; n < count; n++) begin
            p = tracker.clamped_len();
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                prior = $urandom & Mask24;
                newl  = $urandom & Mask24;
            end else if (kind < 4) begin
                newl  = $urandom_range(0, p * 20);
                prior = newl + $urandom_range(1, p * 4);
            end else if (kind < 5) begin
                send_load($urandom_range(0, TableDepth - 1), 24'($urandom));
                continue;
            end else begin
                prior = (kind == 5) ? Mask24 - $urandom_range(0, p * 32) :
                                      $urandom_range(0, p * 40);
                newl  = prior + $urandom_range(0, p * $urandom_range(0, 12));
                if (newl > Mask24) newl = Mask24;
            end
            send_request(prior, newl, $urandom, $urandom_range(0, 2) == 0);
            if (--burst == 0) begin
                idle_sender($urandom_range(0, 6));
                burst = $urandom_range(1, 8);
            end
        end
    endtask

    // Main sequence.
    initial begin
        int unsigned lengths [7] = '{16, 1, 1024, 0, 2047, 7, 3};
        push           = 1'b0;
        i_action       = ActLoad;
        i_table_index  = '0;
        i_page_number  = '0;
        i_prior_length = '0;
        i_new_length   = '0;
        i_last_slot    = '0;
        i_end_of_batch = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        @(posedge i_rst_n);

        write_page_length(16);
        // Directed cases at a page length of 16.
        send_load(1023, 24'hFFFFFF);
        send_load(1022, 24'h000000);
        send_request(0, 0, 32'hFFFF_FFFF, 1'b0);              // no growth from empty
        send_request(5, 5, 32'd4, 1'b0);                      // no growth
        send_request(5, 10, 32'hFFFF_FFFF, 1'b0);             // head run only
        send_request(5, 60, 32'h7FFF_FFFF, 1'b0);             // head, full pages, tail; slot wraps
        send_request(16, 48, 32'h8000_0000, 1'b0);            // page-aligned growth
        send_request(100, 50, 32'd0, 1'b0);                   // shrinking request
        send_request(0, 16 * 31, 32'd0, 1'b0);                // one page too many
        send_request(1, 481, 32'd7, 1'b1);                    // largest legal result count
        send_request(Mask24, Mask24, 32'd0, 1'b0);            // extreme lengths, no growth
        send_request(Mask24 - 40, Mask24, 32'hFFFF_FFFE, 1'b0);
        send_request(1600, 0, 32'd0, 1'b0);                   // page sum wraps below zero
        send_request(0, 16, 32'd0, 1'b0);                     // table depth exceeded
        send_request(0, 0, 32'd0, 1'b1);                      // batch end clears sums

        // Random part across the page length settings.
        foreach (lengths[i]) begin
            if (i != 0) write_page_length(lengths[i]);
            if (i == 0 || i == 2) hold_request = 1'b1;
            random_requests(i == 0 ? 20 : 10);
        end
        idle_sender(1);

        while (tracker.pending_runs.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("covered %0d requests and %0d table loads over %0d page lengths",
                 tracker.requests, tracker.loads, $size(lengths));
        $display("checked %0d runs, %0d of them errors; %0d mismatches",
                 tracker.runs_seen, tracker.error_runs, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_runs.size() == 0) begin
            $display("paged_slot_allocator_tb: clean");
        end else begin
            $display("paged_slot_allocator_tb: errors");
        end
        $finish;
    end

endmodule
